### sv/odrk_pkg.sv
package odrk_pkg;

  // Field widths of the item and register
  localparam int unsigned PIXEL_W     = 32;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned LW_W        = 13;
  localparam int unsigned DITHER_W    = 3;
  localparam int unsigned ROW_W       = 2;

  // Register reset and channel mask
  localparam logic [LW_W-1:0]   LINE_WIDTH_RESET = 13'd640;
  localparam logic [CHAN_W-1:0] CHAN_MASK        = 8'hf8;
  localparam logic [CHAN_W-1:0] CHAN_MAX         = 8'hff;

  typedef logic [PIXEL_W-1:0]  pixel_t;
  typedef logic [CHAN_W-1:0]   chan_t;
  typedef logic [DITHER_W-1:0] dither_t;
  typedef logic [ROW_W-1:0]    row_t;

  // 4x8 ordered pattern, [row mod 4][column mod 8]
  localparam dither_t DITHER_PATTERN [4][8] = '{
    '{3'd0, 3'd5, 3'd6, 3'd3, 3'd7, 3'd2, 3'd1, 3'd4},
    '{3'd7, 3'd2, 3'd1, 3'd4, 3'd0, 3'd5, 3'd6, 3'd3},
    '{3'd1, 3'd4, 3'd7, 3'd2, 3'd6, 3'd3, 3'd0, 3'd5},
    '{3'd6, 3'd3, 3'd0, 3'd5, 3'd1, 3'd4, 3'd7, 3'd2}
  };

endpackage

### sv/odrk_dither.sv
module odrk_dither (
  input  odrk_pkg::pixel_t  px,
  input  odrk_pkg::pixel_t  key,
  input  odrk_pkg::dither_t d,
  output odrk_pkg::pixel_t  result
);
  import odrk_pkg::*;

  logic [CHAN_W:0] r_sum;
  logic [CHAN_W:0] b_sum;
  chan_t           r_sat;
  chan_t           g_sub;
  chan_t           b_sat;
  chan_t           d_ext;
  pixel_t          dithered;

  // Saturating add on red and blue, floored subtract on green
  always_comb begin
    d_ext = CHAN_W'(d);
    r_sum = {1'b0, px[23:16]} + {1'b0, d_ext};
    b_sum = {1'b0, px[7:0]} + {1'b0, d_ext};
    r_sat = r_sum[CHAN_W] ? CHAN_MAX : r_sum[CHAN_W-1:0];
    b_sat = b_sum[CHAN_W] ? CHAN_MAX : b_sum[CHAN_W-1:0];
    g_sub = (px[15:8] >= d_ext) ? (px[15:8] - d_ext) : '0;
    dithered = {8'h00, r_sat & CHAN_MASK, g_sub & CHAN_MASK, b_sat & CHAN_MASK};
  end

  // Keyed pixels and dithered values that hit the key pass through
  assign result = ((px != key) && (dithered != key)) ? dithered : px;

endmodule

### sv/ordered_dither_rgb555_keyed_unit.sv
// Ordered dither to RGB555 with a transparent key taken from each frame's first pixel.
// Pipeline: input stage, then result register; the result is held while out_stall is high.
// One item per cycle; in_stall rises only with both stages full and out_stall high.
// Reset (rst, synchronous): pipeline empty, key 0, column and row 0,
// line width back to 640.
module ordered_dither_rgb555_keyed_unit #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [odrk_pkg::LW_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  odrk_pkg::pixel_t              pixel_in,
  input  logic                          frame_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output odrk_pkg::pixel_t              pixel_out
);
  import odrk_pkg::*;

  localparam int unsigned COL_W = (MAX_WIDTH > 8) ? $clog2(MAX_WIDTH) : 3;
  localparam int unsigned CMP_W = (LW_W > COL_W + 1) ? LW_W : COL_W + 1;
  localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);

  // Last column index for a given register value (zero means one pixel per row)
  function automatic logic [COL_W-1:0] last_col(input logic [LW_W-1:0] lw);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(lw);
    if (ext == '0) begin
      last_col = '0;
    end else if (ext > MAX_W_C) begin
      last_col = COL_W'(MAX_W_C - 1'b1);
    end else begin
      last_col = COL_W'(ext - 1'b1);
    end
  endfunction

  logic [COL_W-1:0] width_last;
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_next;
  logic [COL_W-1:0] col_eff;
  row_t             row;
  row_t             row_next;
  row_t             row_eff;
  pixel_t           key;
  pixel_t           key_next;

  logic    s1_valid;
  pixel_t  s1_px;
  pixel_t  s1_key;
  dither_t s1_d;
  pixel_t  s1_result;

  logic in_take;
  logic s1_adv;
  logic out_free;

  // Handshake: output register frees when empty or taken
  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Raster position and key for the incoming item
  always_comb begin
    key_next = frame_start ? pixel_in : key;
    col_eff  = frame_start ? '0 : col;
    row_eff  = frame_start ? '0 : row;
    if (col_eff > width_last) begin
      col_eff = '0;
    end
    if (col_eff == width_last) begin
      col_next = '0;
      row_next = row_eff + 1'b1;
    end else begin
      col_next = col_eff + 1'b1;
      row_next = row_eff;
    end
  end

  // Config register and raster state
  always_ff @(posedge clk) begin
    if (rst) begin
      width_last <= last_col(LINE_WIDTH_RESET);
      col        <= '0;
      row        <= '0;
      key        <= '0;
    end else begin
      if (cfg_wr_en) begin
        width_last <= last_col(cfg_wr_data);
      end
      if (in_take) begin
        col <= col_next;
        row <= row_next;
        key <= key_next;
      end
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_px  <= pixel_in;
      s1_key <= key_next;
      s1_d   <= DITHER_PATTERN[row_eff][col_eff[2:0]];
    end
  end

  odrk_dither u_dither (
    .px     (s1_px),
    .key    (s1_key),
    .d      (s1_d),
    .result (s1_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pixel_out <= s1_result;
    end
  end

  // Frame start pixel becomes the key seen by its own item
  a_key_capture: assert property (@(posedge clk) disable iff (rst)
    in_take && frame_start |=> s1_key == $past(pixel_in) && key == $past(pixel_in))
    else $error("frame start pixel not captured as key");

  // A pixel equal to its key passes unchanged
  a_key_pass: assert property (@(posedge clk) disable iff (rst)
    s1_adv && (s1_px == s1_key) |=> out_valid && pixel_out == $past(s1_px))
    else $error("keyed pixel altered");

  // Input only stalls when both the input stage and the result register are full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with room in pipeline");

  // Row end wraps the column
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    in_take && !frame_start && col == width_last |=> col == '0)
    else $error("column did not wrap at row end");

endmodule

### tb/sv/ordered_dither_rgb555_keyed_unit_test.sv
module ordered_dither_rgb555_keyed_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import odrk_pkg::pixel_t;
  import odrk_pkg::LW_W;

  localparam int unsigned MAX_LINE = 4096;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam logic [7:0] CHAN_KEEP = 8'hf8;
  localparam logic [LW_W-1:0] WIDTH_AT_RESET = 13'd640;
  localparam logic [LW_W-1:0] WIDTH_ALL_ONES = 13'h1fff;

  // 4x8 ordered pattern, [row mod 4][column mod 8]
  localparam int unsigned DITHER_TABLE [4][8] = '{
    '{0, 5, 6, 3, 7, 2, 1, 4},
    '{7, 2, 1, 4, 0, 5, 6, 3},
    '{1, 4, 7, 2, 6, 3, 0, 5},
    '{6, 3, 0, 5, 1, 4, 7, 2}
  };

  // channel values near the saturation and floor points
  localparam logic [7:0] EDGE_LEVELS [6] = '{8'h00, 8'h01, 8'h07, 8'hf8, 8'hfa, 8'hff};

  // widths used by the random phases, small ones mostly
  localparam int unsigned NUM_PHASES = 13;
  localparam logic [LW_W-1:0] PHASE_WIDTHS [NUM_PHASES] = '{
    13'd8, 13'd13, 13'd24, 13'd0, 13'd16, 13'd3, 13'd40,
    13'd8, 13'd1, 13'd64, 13'd640, 13'd4096, 13'd16
  };
  localparam int unsigned PHASE_ITEMS = 130;
  localparam int unsigned LONG_ITEMS = 230;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [LW_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  pixel_t pixel_in;
  logic frame_start;
  logic out_valid;
  logic out_stall;
  pixel_t pixel_out;

  // prediction state
  logic [LW_W-1:0] width_reg = WIDTH_AT_RESET;
  pixel_t key_pixel = '0;
  int unsigned column_pos = 0;
  logic [1:0] row_idx = '0;

  pixel_t expected_pixels [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned frame_left = 0;
  bit bursts_on = 1'b1;
  pixel_t want_pixel;

  ordered_dither_rgb555_keyed_unit #(
    .MAX_WIDTH(MAX_LINE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pixel_in(pixel_in),
    .frame_start(frame_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_out(pixel_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // advance the raster position and return the expected output pixel
  function automatic pixel_t predict_pixel_out(pixel_t px, logic fs);
    int unsigned w;
    int unsigned d;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    pixel_t dithered;
    pixel_t result;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_LINE) ? MAX_LINE : width_reg);
    result = px;
    if (fs) begin
      key_pixel = px;
      column_pos = 0;
      row_idx = '0;
    end
    if (column_pos >= w) column_pos = 0;
    if (px != key_pixel) begin
      d = DITHER_TABLE[row_idx][column_pos % 8];
      r = px[23:16] + d;
      if (r > 255) r = 255;
      g = (px[15:8] >= d) ? px[15:8] - d : 0;
      b = px[7:0] + d;
      if (b > 255) b = 255;
      dithered = {8'h00, r[7:0] & CHAN_KEEP, g[7:0] & CHAN_KEEP, b[7:0] & CHAN_KEEP};
      if (dithered != key_pixel) result = dithered;
    end
    column_pos++;
    if (column_pos >= w) begin
      column_pos = 0;
      row_idx++;
    end
    return result;
  endfunction

  // key candidates: often already in dithered form so it can collide with outputs
  function automatic pixel_t pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return $urandom & 32'h00f8f8f8;
    if (sel < 65) return '0;
    return $urandom;
  endfunction

  function automatic pixel_t pick_pixel();
    int unsigned sel;
    pixel_t px;
    sel = $urandom_range(0, 99);
    px = $urandom;
    if (sel < 15) begin
      px = key_pixel;
    end else if (sel < 35) begin
      // differs from the key only in bits that the dither may fold back onto it
      px = (key_pixel & 32'h00f8f8f8) | ($urandom & 32'hff070707);
    end else if (sel < 45) begin
      px = {px[31:24], EDGE_LEVELS[$urandom_range(0, 5)],
            EDGE_LEVELS[$urandom_range(0, 5)], EDGE_LEVELS[$urandom_range(0, 5)]};
    end
    return px;
  endfunction

  // one item on the input channel, with an optional gap ahead of it
  task automatic send_pixel(input pixel_t px, input logic fs);
    if (bursts_on && $urandom_range(0, 9) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 17)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    pixel_in <= px;
    frame_start <= fs;
    do @(posedge clk); while (in_stall);
    expected_pixels.push_back(predict_pixel_out(px, fs));
  endtask

  // stop sending and let every pending item come out
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_line_width(input logic [LW_W-1:0] w);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    width_reg = w;
  endtask

  task automatic run_frames(input int unsigned count);
    pixel_t px;
    logic fs;
    repeat (count) begin
      fs = 1'b0;
      if (frame_left == 0) begin
        fs = 1'b1;
        frame_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : $urandom_range(8, 160);
      end
      px = fs ? pick_key() : pick_pixel();
      frame_left--;
      send_pixel(px, fs);
    end
  endtask

  // key still at its reset value of zero
  task automatic test_before_first_frame();
    send_pixel(32'h00000000, 1'b0);
    send_pixel(32'h00000002, 1'b0);
    send_pixel(32'hffffffff, 1'b0);
    send_pixel(32'hff000000, 1'b0);
  endtask

  task automatic test_field_extremes();
    send_pixel(32'h12345678, 1'b1);
    send_pixel(32'hffffffff, 1'b0);
    send_pixel(32'h00000000, 1'b0);
    send_pixel(32'h00ff00ff, 1'b0);
    send_pixel(32'hff00ff00, 1'b0);
    send_pixel(32'h80808080, 1'b0);
    send_pixel(32'h7f7f7f7f, 1'b0);
  endtask

  // key in dithered form, near misses, and back-to-back frame starts
  task automatic test_frame_key();
    send_pixel(32'h00f8f8f8, 1'b1);
    send_pixel(32'h00f8f8f8, 1'b0);
    send_pixel(32'h00fbfcff, 1'b0);
    send_pixel(32'h01f8f8f8, 1'b1);
    send_pixel(32'h00000000, 1'b1);
  endtask

  // zero width acts as one pixel per row, so every item steps the row
  task automatic test_zero_width();
    set_line_width('0);
    send_pixel(32'h00000000, 1'b1);
    repeat (4) send_pixel(32'h00404040, 1'b0);
  endtask

  task automatic test_random_frames();
    for (int i = 0; i < NUM_PHASES; i++) begin
      bursts_on = (i < NUM_PHASES - 1);
      set_line_width(PHASE_WIDTHS[i]);
      run_frames(PHASE_ITEMS);
    end
  endtask

  // oversized width saturates; a stretch of one long row with no gaps
  task automatic test_long_line();
    bursts_on = 1'b0;
    set_line_width(WIDTH_ALL_ONES);
    frame_left = 0;
    send_pixel(pick_key(), 1'b1);
    repeat (LONG_ITEMS) send_pixel(pick_pixel(), 1'b0);
  endtask

  // output side stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (bursts_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t ns: unexpected item, expected none, got pixel_out %h", $time, pixel_out);
        error_count++;
      end else begin
        want_pixel = expected_pixels.pop_front();
        if (pixel_out !== want_pixel) begin
          $display("%0t ns: pixel_out expected %h, got %h", $time, want_pixel, pixel_out);
          error_count++;
        end
      end
    end
  end

  // timeout
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ordered_dither_rgb555_keyed_unit regression: fail");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    pixel_in = '0;
    frame_start = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_before_first_frame();
    test_field_extremes();
    test_frame_key();
    test_zero_width();
    test_random_frames();
    test_long_line();
    wait_idle();

    if (error_count == 0) begin
      $display("ordered_dither_rgb555_keyed_unit regression: pass");
    end else begin
      $display("ordered_dither_rgb555_keyed_unit regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
sv/odrk_pkg.sv
sv/odrk_dither.sv
sv/ordered_dither_rgb555_keyed_unit.sv
tb/sv/ordered_dither_rgb555_keyed_unit_test.sv
